// File: hw/rtl/deqi_pkg.sv
`default_nettype none

package deqi_pkg;

    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 6;
    localparam int OUT_W    = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 2'd0,
        KIND_PUSH_FRONT = 2'd1,
        KIND_READ       = 2'd2,
        KIND_CLEAR      = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic exec;         // run a push or clear and load its result
        logic issue_read;   // launch the memory read of an indexed read
        logic finish_read;  // load the result of the read in flight
    } deqi_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;     // output register empty or being taken
    } deqi_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/double_ended_queue_indexed.sv
`default_nettype none

// channel   dir  tdata                                         tuser
// s_axis    in   value[31:0] index[37:32] pad[39:38]           kind[1:0]
// m_axis    out  read_data[31:0] front_value[63:32]            status[1:0]
//                back_value[95:64] count[102:96] is_empty[103]
//
// Push and clear load their result at the accepting edge, so the beat shows
// in the next cycle; an indexed read first loads the registered read port of the
// element memory and holds s_tready low in S_READ until the output register is free.
// Pushes and clears can follow back to back while m_tready stays high.
// Reset empties the queue at once; no clearing pass is needed.
// s_tready is low while a beat waits in the output register with m_tready low.

module double_ended_queue_indexed
    import deqi_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [39:0]  s_tdata,   // value, index, zero pad
    input  wire logic [1:0]   s_tuser,   // kind
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // read_data, front_value, back_value, count, is_empty
    output logic [1:0]        m_tuser    // status
);

    deqi_cmd_t           cmd;
    deqi_stat_t          stat;
    kind_t               kind;
    logic [OUT_W-1:0]    read_data;
    logic [OUT_W-1:0]    front_value;
    logic [OUT_W-1:0]    back_value;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    status_t             status;

    assign kind = kind_t'(s_tuser);

    deqi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (kind),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    deqi_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .kind        (kind),
        .value       (s_tdata[VALUE_W-1:0]),
        .index       (s_tdata[VALUE_W+INDEX_W-1:VALUE_W]),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .read_data   (read_data),
        .front_value (front_value),
        .back_value  (back_value),
        .count       (count),
        .is_empty    (is_empty),
        .status      (status)
    );

    assign m_tdata = {is_empty, count, back_value, front_value, read_data};
    assign m_tuser = status;

    // a read keeps the input blocked in the cycle after its beat is taken
    a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == KIND_READ) |=> !s_tready)
        else $error("input taken while a read is in flight");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_RANGE) |-> (m_tdata[31:0] == 32'd0))
        else $error("out-of-range read returned data");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_FULL) |-> (m_tdata[102:96] == COUNT_W'(DEPTH)))
        else $error("dropped push without a full queue");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[103] |-> (m_tdata[95:32] == 64'd0))
        else $error("empty queue shows front or back data");

endmodule

`default_nettype wire

// File: hw/rtl/deqi_ctrl.sv
`default_nettype none

module deqi_ctrl
    import deqi_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire kind_t      in_kind,
    output logic            in_ready,
    input  wire deqi_stat_t stat,
    output deqi_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next       = state_reg;
        in_ready         = 1'b0;
        cmd.exec         = 1'b0;
        cmd.issue_read   = 1'b0;
        cmd.finish_read  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    if (in_kind == KIND_READ)
                    begin
                        cmd.issue_read = 1'b1;
                        state_next     = S_READ;
                    end
                    else
                    begin
                        cmd.exec = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                // hold until the output register can take the beat
                if (stat.out_free)
                begin
                    cmd.finish_read = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/deqi_dpath.sv
`default_nettype none

module deqi_dpath
    import deqi_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire kind_t                 kind,
    input  wire logic [VALUE_W-1:0]    value,
    input  wire logic [INDEX_W-1:0]    index,
    input  wire deqi_cmd_t             cmd,
    output deqi_stat_t                 stat,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic [OUT_W-1:0]           read_data,
    output logic [OUT_W-1:0]           front_value,
    output logic [OUT_W-1:0]           back_value,
    output logic [COUNT_W-1:0]         count,
    output logic                       is_empty,
    output status_t                    status
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [PW-1:0]         head_reg;
    logic [PW-1:0]         head_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [DATA_WIDTH-1:0] front_reg;
    logic [DATA_WIDTH-1:0] front_next;
    logic [DATA_WIDTH-1:0] back_reg;
    logic [DATA_WIDTH-1:0] back_next;
    logic [DATA_WIDTH-1:0] rd_q_reg;
    logic                  rd_ok_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_W-1:0]      out_read_reg;
    logic [OUT_W-1:0]      out_front_reg;
    logic [OUT_W-1:0]      out_back_reg;
    logic [COUNT_W-1:0]    out_count_reg;
    logic                  out_empty_reg;
    status_t               out_status_reg;

    logic [DATA_WIDTH-1:0] din;
    logic                  full;
    logic                  in_range;
    logic [PW:0]           tail_sum;
    logic [PW-1:0]         tail_slot;
    logic [PW-1:0]         head_dec;
    logic [PW:0]           rd_sum;
    logic [PW-1:0]         rd_slot;
    logic                  mem_we;
    logic [PW-1:0]         mem_waddr;
    status_t               op_status;

    always_comb
    begin
        din      = DATA_WIDTH'($unsigned(value));
        full     = (count_reg == CW'(DEPTH));
        in_range = (XW'(index) < XW'(count_reg));

        // ring slot one past the back element
        tail_sum = {1'b0, head_reg} + (PW+1)'(count_reg);
        if (tail_sum >= (PW+1)'(DEPTH))
        begin
            tail_sum = tail_sum - (PW+1)'(DEPTH);
        end
        tail_slot = tail_sum[PW-1:0];

        head_dec = (head_reg == '0) ? PW'(DEPTH - 1) : head_reg - PW'(1);

        // out-of-range reads may land anywhere; their data is dropped
        rd_sum = {1'b0, head_reg} + {1'b0, PW'(index)};
        if (rd_sum >= (PW+1)'(DEPTH))
        begin
            rd_sum = rd_sum - (PW+1)'(DEPTH);
        end
        rd_slot = rd_sum[PW-1:0];
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        front_next = front_reg;
        back_next  = back_reg;
        mem_we     = 1'b0;
        mem_waddr  = tail_slot;
        op_status  = ST_OK;
        if (cmd.exec)
        begin
            case (kind)
                KIND_PUSH_BACK:
                begin
                    if (full)
                    begin
                        op_status = ST_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                        back_next  = din;
                        if (count_reg == '0)
                        begin
                            front_next = din;
                        end
                    end
                end
                KIND_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        op_status = ST_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = head_dec;
                        head_next  = head_dec;
                        count_next = count_reg + CW'(1);
                        front_next = din;
                        if (count_reg == '0)
                        begin
                            back_next = din;
                        end
                    end
                end
                KIND_CLEAR:
                begin
                    count_next = '0;
                    head_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        stat.out_free = !out_valid_reg || out_ready;
        if (cmd.exec || cmd.finish_read)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= din;
        end
        if (cmd.issue_read)
        begin
            rd_q_reg <= mem[rd_slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cmd.issue_read)
            begin
                rd_ok_reg <= in_range;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        back_reg  <= back_next;
        if (cmd.exec)
        begin
            out_read_reg   <= '0;
            out_front_reg  <= (count_next == '0) ? '0 : OUT_W'(front_next);
            out_back_reg   <= (count_next == '0) ? '0 : OUT_W'(back_next);
            out_count_reg  <= COUNT_W'(count_next);
            out_empty_reg  <= (count_next == '0);
            out_status_reg <= op_status;
        end
        else if (cmd.finish_read)
        begin
            out_read_reg   <= rd_ok_reg ? OUT_W'(rd_q_reg) : '0;
            out_front_reg  <= (count_reg == '0) ? '0 : OUT_W'(front_reg);
            out_back_reg   <= (count_reg == '0) ? '0 : OUT_W'(back_reg);
            out_count_reg  <= COUNT_W'(count_reg);
            out_empty_reg  <= (count_reg == '0);
            out_status_reg <= rd_ok_reg ? ST_OK : ST_RANGE;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = out_read_reg;
    assign front_value = out_front_reg;
    assign back_value  = out_back_reg;
    assign count       = out_count_reg;
    assign is_empty    = out_empty_reg;
    assign status      = out_status_reg;

endmodule

`default_nettype wire
